@@ design/pip_pkg.sv @@
// Shared constants and types for the point-in-polygon test block.
// Used by pip_edge_unit and point_in_polygon_test; no dependencies.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = 7;
  // Coordinate differences carry one extra bit, products twice that
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int MIN_VERTICES = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Step strobes from the sequencer to the edge datapath
  typedef struct packed {
    logic load;   // capture differences and range flags of one edge
    logic mul_a;  // multiply (px - x1) * (y2 - y1)
    logic mul_b;  // multiply (py - y1) * (x2 - x1)
  } pip_edge_ctrl_t;

endpackage

@@ design/pip_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pip_edge_unit.sv @@
// Edge crossing datapath: range flags, one shared signed multiplier, one wide compare.
// Depends on pip_pkg.
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic                      clk,
  input  pip_edge_ctrl_t            ctrl,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] x1,
  input  logic signed [COORD_W-1:0] y1,
  input  logic signed [COORD_W-1:0] x2,
  input  logic signed [COORD_W-1:0] y2,
  output logic                      crossed
);

  logic signed [COORD_W-1:0] ymin;
  logic signed [COORD_W-1:0] ymax;
  logic signed [COORD_W-1:0] xmax;
  logic signed [DIFF_W-1:0]  ex;
  logic signed [DIFF_W-1:0]  ey;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic                      in_range;
  logic                      vertical;
  logic                      dy_pos;
  logic signed [DIFF_W-1:0]  op_a;
  logic signed [DIFF_W-1:0]  op_b;
  logic signed [PROD_W-1:0]  mul;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_a;
  logic                      le;

  // Bounding values of the edge
  assign ymin = (y1 < y2) ? y1 : y2;
  assign ymax = (y1 < y2) ? y2 : y1;
  assign xmax = (x1 < x2) ? x2 : x1;

  // Capture differences and flags of the current edge
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ex       <= {px[COORD_W-1], px} - {x1[COORD_W-1], x1};
      ey       <= {py[COORD_W-1], py} - {y1[COORD_W-1], y1};
      dx       <= {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
      dy       <= {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
      in_range <= (py > ymin) && (py <= ymax) && (px <= xmax) && (y1 != y2);
      vertical <= (x1 == x2);
      dy_pos   <= (y2 > y1);
    end
  end

  // Shared multiplier: first the point side, then the intercept side
  assign op_a = ctrl.mul_a ? ex : ey;
  assign op_b = ctrl.mul_a ? dy : dx;
  assign mul  = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_a || ctrl.mul_b) begin
      prod <= mul;
    end
    if (ctrl.mul_b) begin
      prod_a <= prod;
    end
  end

  // Swap the sides of the compare when the edge runs downward
  assign le      = dy_pos ? (prod_a <= prod) : (prod <= prod_a);
  assign crossed = in_range && (vertical || le);

endmodule

@@ design/point_in_polygon_test.sv @@
// Ray-casting point-in-polygon test over a stored vertex list; depends on pip_pkg,
// pip_ram and pip_edge_unit. A query steps each of its edges (saturated vertex_count)
// through the load, first multiply, second multiply and compare states on the one
// shared multiplier and compare, or goes straight to output below three vertices;
// input is ready again once the result is registered, after any untaken result leaves.
// Synchronous reset clears the sequencer, output valid and vertex_count (to 3).
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [COUNT_W-1:0]  cfg_wdata,      // vertex_count
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [5:0] vertex_index, [37:6] vertex_x, [69:38] vertex_y,
  // [101:70] point_x, [133:102] point_y, [135:134] zero
  input  logic [135:0]        s_axis_tdata,
  input  logic                s_axis_tuser,   // [0] command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata    // [0] inside_res, [7:1] zero
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_RD0   = 8'b00000010,
    ST_FIRST = 8'b00000100,
    ST_LOAD  = 8'b00001000,
    ST_MULA  = 8'b00010000,
    ST_MULB  = 8'b00100000,
    ST_CMP   = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [COUNT_W-1:0]        vertex_count;
  logic [COUNT_W-1:0]        n_sat;
  logic                      n_small;
  logic [ADDR_W-1:0]         last_idx;
  logic [ADDR_W-1:0]         edge_idx;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      parity;
  logic                      in_xfer;
  logic                      wr_en;
  logic                      query;
  logic                      out_free;
  logic [2*COORD_W-1:0]      rd_data;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic                      wrap;
  logic                      crossed;
  pip_edge_ctrl_t            ctrl;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign query         = in_xfer && (s_axis_tuser == CMD_QUERY);
  assign wr_en         = in_xfer && (s_axis_tuser == CMD_WRITE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Saturate the vertex count to the store depth
  assign n_sat   = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                           : vertex_count;
  assign n_small = (vertex_count < COUNT_W'(MIN_VERTICES));

  // Hold the vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_W'(MIN_VERTICES);
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  // Vertex store, x in the low half and y in the high half
  pip_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s_axis_tdata[ADDR_W-1:0]),
    .wdata({s_axis_tdata[69:38], s_axis_tdata[37:6]}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Close the polygon on the last edge
  assign wrap  = (edge_idx == last_idx);
  assign cur_x = wrap ? first_x : rd_data[COORD_W-1:0];
  assign cur_y = wrap ? first_y : rd_data[2*COORD_W-1:COORD_W];

  assign ctrl.load  = (state == ST_LOAD);
  assign ctrl.mul_a = (state == ST_MULA);
  assign ctrl.mul_b = (state == ST_MULB);

  pip_edge_unit u_edge (
    .clk    (clk),
    .ctrl   (ctrl),
    .px     (px),
    .py     (py),
    .x1     (prev_x),
    .y1     (prev_y),
    .x2     (cur_x),
    .y2     (cur_y),
    .crossed(crossed)
  );

  // Sequence one query edge by edge
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query) begin
          state_next = n_small ? ST_OUT : ST_RD0;
        end
      end
      ST_RD0:   state_next = ST_FIRST;
      ST_FIRST: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_MULA;
      ST_MULA:  state_next = ST_MULB;
      ST_MULB:  state_next = ST_CMP;
      ST_CMP:   state_next = wrap ? ST_OUT : ST_LOAD;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance counters and capture vertices
  always_ff @(posedge clk) begin
    if (query) begin
      px       <= s_axis_tdata[101:70];
      py       <= s_axis_tdata[133:102];
      last_idx <= ADDR_W'(n_sat - COUNT_W'(1));
      rd_addr  <= '0;
      edge_idx <= '0;
      parity   <= 1'b0;
    end
    if (state == ST_RD0) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
    if (state == ST_FIRST) begin
      first_x <= rd_data[COORD_W-1:0];
      first_y <= rd_data[2*COORD_W-1:COORD_W];
      prev_x  <= rd_data[COORD_W-1:0];
      prev_y  <= rd_data[2*COORD_W-1:COORD_W];
    end
    if (state == ST_LOAD) begin
      prev_x  <= cur_x;
      prev_y  <= cur_y;
      rd_addr <= rd_addr + ADDR_W'(1);
    end
    if (state == ST_CMP) begin
      parity <= parity ^ crossed;
      if (!wrap) begin
        edge_idx <= edge_idx + ADDR_W'(1);
      end
    end
  end

  // Hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {7'd0, parity};
    end
  end

`ifndef ASSERT_OFF
  a_small_count: assert property (@(posedge clk) disable iff (rst)
    query && n_small |=> state == ST_OUT && !parity)
    else $error("short polygon query did not go straight to a zero result");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && m_axis_tvalid && !m_axis_tready |=> state == ST_OUT)
    else $error("result overwrote an untaken output");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> edge_idx <= last_idx)
    else $error("edge counter ran past the last edge");

  a_last_edge: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP && wrap |=> state == ST_OUT)
    else $error("query did not finish after the closing edge");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD || state == ST_MULA || state == ST_CMP |-> !s_axis_tready)
    else $error("input taken while an edge is in flight");
`endif

endmodule
